@@ rtl/core/wbps_pkg.sv @@
`default_nettype none

package wbps_pkg;

  // Window depth in bytes and width of the per-buffer byte counter.
  localparam int MAX_PATTERN = 32;
  localparam int OFFSET_BITS = 32;

  // Pattern storage is fixed by the register map: four 64-bit words.
  localparam int PATTERN_WORDS = 4;
  localparam int PATTERN_BYTES = PATTERN_WORDS * 8;

  // Field widths.
  localparam int LEN_W    = 6;
  localparam int BYTE_W   = 8;
  localparam int CARE_W   = 32;
  localparam int RESULT_W = 32;

  // Configuration port geometry: 64-bit registers at 8-byte spacing.
  localparam int PDATA_W   = 64;
  localparam int PADDR_W   = 6;
  localparam int REG_IDX_W = 3;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_WORD_0 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_WORD_1 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_WORD_2 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_WORD_3 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CARE_MASK      = 3'd5;

  // Reset values.
  localparam logic [LEN_W-1:0]  LEN_RESET  = 6'd1;
  localparam logic [CARE_W-1:0] CARE_RESET = '1;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [LEN_W-1:0]                       pattern_length;
    logic [PATTERN_BYTES-1:0][BYTE_W-1:0]   pattern;
    logic [CARE_W-1:0]                      care_mask;
  } cfg_t;

  typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_t;

  // Length actually compared: zero counts as one, and the window depth caps it.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] len;
    len = raw;
    if (len == '0) begin
      len = LEN_W'(1);
    end
    if (32'(len) > MAX_PATTERN) begin
      len = LEN_W'(MAX_PATTERN);
    end
    return len;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/wildcard_byte_pattern_scanner.sv @@
// Channel  | Signals                              | Beat
// ---------+--------------------------------------+-------------------------------
// input    | in_valid, in_stall, data_byte,       | one buffer byte
//          | last_byte                            |
// output   | out_valid, out_stall, match_offset   | start offset of one full match
// config   | psel, penable, pwrite, paddr,        | one 64-bit register write/read
//          | pwdata, prdata, pready               |
//
// One byte is accepted per cycle while in_stall is low; its match result passes
// through the window register and then the output register.
// Reset (rst, synchronous) restores the register reset values and empties both stages.
// A stalled output holds its beat; the input stalls only once the window stage
// also holds a beat that cannot move on.
`default_nettype none

module wildcard_byte_pattern_scanner (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [wbps_pkg::BYTE_W-1:0]   data_byte,
  input  wire logic                          last_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [wbps_pkg::RESULT_W-1:0] match_offset,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [wbps_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [wbps_pkg::PDATA_W-1:0]  pwdata,
  output logic      [wbps_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);

  wbps_pkg::cfg_t                   cfg;
  wbps_pkg::window_t                window;
  logic [wbps_pkg::OFFSET_BITS-1:0] byte_count;
  logic                             s1_valid;
  logic                             s1_ready;

  wbps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wbps_window u_window (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .s1_ready   (s1_ready),
    .s1_valid   (s1_valid),
    .window     (window),
    .byte_count (byte_count)
  );

  wbps_match u_match (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .s1_valid     (s1_valid),
    .s1_ready     (s1_ready),
    .window       (window),
    .byte_count   (byte_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .match_offset (match_offset)
  );

endmodule

`default_nettype wire

@@ rtl/core/wbps_cfg.sv @@
`default_nettype none

module wbps_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [wbps_pkg::PADDR_W-1:0] paddr,
  input  wire logic [wbps_pkg::PDATA_W-1:0] pwdata,
  output logic      [wbps_pkg::PDATA_W-1:0] prdata,
  output logic                              pready,
  output wbps_pkg::cfg_t                    cfg
);

  logic [wbps_pkg::LEN_W-1:0]   pattern_length;
  logic [wbps_pkg::PDATA_W-1:0] pattern_word [wbps_pkg::PATTERN_WORDS];
  logic [wbps_pkg::CARE_W-1:0]  care_mask;
  logic [wbps_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_en;

  // Registers sit on 8-byte boundaries; the low address bits select nothing.
  assign reg_idx = paddr[wbps_pkg::PADDR_W-1:wbps_pkg::PADDR_W-wbps_pkg::REG_IDX_W];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes; addresses past the map are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= wbps_pkg::LEN_RESET;
      for (int k = 0; k < wbps_pkg::PATTERN_WORDS; k++) begin
        pattern_word[k] <= '0;
      end
      care_mask <= wbps_pkg::CARE_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        wbps_pkg::REG_PATTERN_LENGTH: pattern_length  <= pwdata[wbps_pkg::LEN_W-1:0];
        wbps_pkg::REG_PATTERN_WORD_0: pattern_word[0] <= pwdata;
        wbps_pkg::REG_PATTERN_WORD_1: pattern_word[1] <= pwdata;
        wbps_pkg::REG_PATTERN_WORD_2: pattern_word[2] <= pwdata;
        wbps_pkg::REG_PATTERN_WORD_3: pattern_word[3] <= pwdata;
        wbps_pkg::REG_CARE_MASK:      care_mask       <= pwdata[wbps_pkg::CARE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_idx)
      wbps_pkg::REG_PATTERN_LENGTH: prdata = wbps_pkg::PDATA_W'(pattern_length);
      wbps_pkg::REG_PATTERN_WORD_0: prdata = pattern_word[0];
      wbps_pkg::REG_PATTERN_WORD_1: prdata = pattern_word[1];
      wbps_pkg::REG_PATTERN_WORD_2: prdata = pattern_word[2];
      wbps_pkg::REG_PATTERN_WORD_3: prdata = pattern_word[3];
      wbps_pkg::REG_CARE_MASK:      prdata = wbps_pkg::PDATA_W'(care_mask);
      default:                      prdata = '0;
    endcase
  end

  // Pattern byte i of the whole pattern sits at bits 8i of the word chain.
  assign cfg.pattern_length = pattern_length;
  assign cfg.pattern        = {pattern_word[3], pattern_word[2],
                               pattern_word[1], pattern_word[0]};
  assign cfg.care_mask      = care_mask;

endmodule

`default_nettype wire

@@ rtl/core/wbps_window.sv @@
`default_nettype none

module wbps_window (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [wbps_pkg::BYTE_W-1:0]     data_byte,
  input  wire logic                            last_byte,
  input  wire logic                            s1_ready,
  output logic                                 s1_valid,
  output wbps_pkg::window_t                    window,
  output logic      [wbps_pkg::OFFSET_BITS-1:0] byte_count
);

  localparam logic [wbps_pkg::OFFSET_BITS-1:0] COUNT_MAX = '1;

  logic                               accept;
  logic                               last_pend;
  logic [wbps_pkg::OFFSET_BITS-1:0]   count_base;
  logic [wbps_pkg::OFFSET_BITS-1:0]   byte_count_next;

  // The window is shared state, so a new beat waits while the held one is unread.
  assign in_stall = s1_valid && !s1_ready;
  assign accept   = in_valid && !in_stall;

  // The previous beat closed a buffer: count restarts; the counter saturates.
  assign count_base      = last_pend ? '0 : byte_count;
  assign byte_count_next = (count_base == COUNT_MAX) ? count_base
                                                     : count_base + 1'b1;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      last_pend  <= 1'b0;
      byte_count <= '0;
    end else if (accept) begin
      s1_valid   <= 1'b1;
      last_pend  <= last_byte;
      byte_count <= byte_count_next;
    end else if (s1_ready) begin
      s1_valid <= 1'b0;
    end
  end

  // Newest byte enters at position zero.
  always_ff @(posedge clk) begin
    if (accept) begin
      window <= {window[wbps_pkg::MAX_PATTERN-2:0], data_byte};
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/wbps_match.sv @@
`default_nettype none

module wbps_match (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wbps_pkg::cfg_t                        cfg,
  input  wire logic                             s1_valid,
  output logic                                  s1_ready,
  input  wbps_pkg::window_t                     window,
  input  wire logic [wbps_pkg::OFFSET_BITS-1:0] byte_count,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [wbps_pkg::RESULT_W-1:0]    match_offset
);

  logic [wbps_pkg::LEN_W-1:0]       len;
  logic [wbps_pkg::OFFSET_BITS-1:0] len_ext;
  logic [wbps_pkg::OFFSET_BITS-1:0] start;
  logic [wbps_pkg::MAX_PATTERN-1:0] pos_ok;
  logic                             enough;
  logic                             hit;

  assign len     = wbps_pkg::eff_len(cfg.pattern_length);
  assign len_ext = wbps_pkg::OFFSET_BITS'(len);
  assign enough  = byte_count >= len_ext;
  assign start   = byte_count - len_ext;

  // Window position j holds the byte that lines up with pattern byte len-1-j.
  always_comb begin
    logic [wbps_pkg::LEN_W:0] pat_idx;
    for (int j = 0; j < wbps_pkg::MAX_PATTERN; j++) begin
      pat_idx   = (wbps_pkg::LEN_W + 1)'(len) - (wbps_pkg::LEN_W + 1)'(j) - 1'b1;
      pos_ok[j] = 1'b1;
      if ((wbps_pkg::LEN_W + 1)'(j) < (wbps_pkg::LEN_W + 1)'(len) &&
          32'(pat_idx) < wbps_pkg::PATTERN_BYTES) begin
        if (cfg.care_mask[pat_idx[$clog2(wbps_pkg::PATTERN_BYTES)-1:0]]) begin
          pos_ok[j] = window[j] ==
                      cfg.pattern[pat_idx[$clog2(wbps_pkg::PATTERN_BYTES)-1:0]];
        end
      end
    end
  end

  assign hit      = enough && (&pos_ok);
  assign s1_ready = !out_valid || !out_stall;

  // Output register; it frees itself when the waiting beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_ready) begin
      out_valid <= hit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      match_offset <= wbps_pkg::RESULT_W'(start);
    end
  end

endmodule

`default_nettype wire

@@ dv/wildcard_byte_pattern_scanner_tb.sv @@
`timescale 1ns / 100ps

module wildcard_byte_pattern_scanner_tb;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int REPORT_MAX    = 10;

  // Clock, reset and the signals the testbench drives.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [wbps_pkg::BYTE_W-1:0] data_byte = '0;
  logic last_byte = 1'b0;
  logic out_stall = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [wbps_pkg::PADDR_W-1:0] paddr = '0;
  logic [wbps_pkg::PDATA_W-1:0] pwdata = '0;

  wire logic in_stall;
  wire logic out_valid;
  wire logic [wbps_pkg::RESULT_W-1:0] match_offset;
  wire logic [wbps_pkg::PDATA_W-1:0] prdata;
  wire logic pready;

  // Scanner state and configuration as the testbench expects them.
  logic [wbps_pkg::LEN_W-1:0]       cfg_len = wbps_pkg::LEN_RESET;
  logic [63:0]                      cfg_word [wbps_pkg::PATTERN_WORDS] = '{default: '0};
  logic [wbps_pkg::CARE_W-1:0]      cfg_care = wbps_pkg::CARE_RESET;
  logic [wbps_pkg::BYTE_W-1:0]      scan_window [wbps_pkg::MAX_PATTERN] = '{default: '0};
  logic [wbps_pkg::OFFSET_BITS-1:0] bytes_in_buffer = '0;
  logic [wbps_pkg::RESULT_W-1:0]    offset_q [$];

  // Knobs for the two sides and run statistics.
  bit src_idle_en = 1'b0;
  bit sink_idle_en = 1'b0;
  int stall_left = 0;
  int hold_left = 0;
  int cycle_cnt = 0;
  int beats_sent = 0;
  int offsets_checked = 0;
  int setting_cnt = 0;
  int fail_cnt = 0;

  wildcard_byte_pattern_scanner u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .match_offset (match_offset),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #4 clk = ~clk;

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result sink: a long hold takes priority over random stall bursts.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void note_failure(input string what,
                                       input logic [wbps_pkg::RESULT_W-1:0] want,
                                       input logic [wbps_pkg::RESULT_W-1:0] got);
    fail_cnt++;
    if (fail_cnt <= REPORT_MAX) begin
      $display("[%0t] %s: expected offset %0d, got %0d", $realtime, what, want, got);
    end
  endfunction

  // Every accepted result beat is compared with the oldest expected offset.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (offset_q.size() == 0) begin
        note_failure("unexpected match", '0, match_offset);
      end else begin
        if (match_offset !== offset_q[0]) begin
          note_failure("wrong match offset", offset_q[0], match_offset);
        end
        void'(offset_q.pop_front());
      end
      offsets_checked++;
    end
  end

  function automatic logic [wbps_pkg::BYTE_W-1:0] pattern_byte(input int unsigned pos);
    return cfg_word[pos >> 3][(pos & 7) * 8 +: 8];
  endfunction

  // A length of zero compares one byte; lengths beyond the window are capped.
  function automatic int unsigned active_length();
    if (cfg_len == '0) begin
      return 1;
    end
    if (int'(cfg_len) > wbps_pkg::MAX_PATTERN) begin
      return wbps_pkg::MAX_PATTERN;
    end
    return int'(cfg_len);
  endfunction

  // Shift one accepted byte into the window and queue the offset of a full match.
  function automatic void scan_byte(input logic [wbps_pkg::BYTE_W-1:0] value,
                                    input logic is_last);
    int unsigned len;
    bit hit;
    for (int k = wbps_pkg::MAX_PATTERN - 1; k > 0; k--) begin
      scan_window[k] = scan_window[k - 1];
    end
    scan_window[0] = value;
    if (bytes_in_buffer != '1) begin
      bytes_in_buffer = bytes_in_buffer + 1'b1;
    end
    len = active_length();
    hit = (bytes_in_buffer >= wbps_pkg::OFFSET_BITS'(len));
    for (int unsigned i = 0; i < len; i++) begin
      if (hit && cfg_care[i] && scan_window[len - 1 - i] != pattern_byte(i)) begin
        hit = 1'b0;
      end
    end
    if (hit) begin
      offset_q.push_back(wbps_pkg::RESULT_W'(bytes_in_buffer -
                                             wbps_pkg::OFFSET_BITS'(len)));
    end
    if (is_last) begin
      bytes_in_buffer = '0;
    end
  endfunction

  // Offer one byte, with an optional idle burst first, and wait for it to be taken.
  task automatic send_byte(input logic [wbps_pkg::BYTE_W-1:0] value, input logic is_last);
    int gap;
    gap = 0;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= value;
    last_byte <= is_last;
    do begin
      @(posedge clk);
    end while (in_stall);
    scan_byte(value, is_last);
    beats_sent++;
  endtask

  // Stop offering bytes, wait for every expected offset, then let the pipeline empty.
  task automatic end_phase();
    @(negedge clk);
    in_valid <= 1'b0;
    while (offset_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [wbps_pkg::REG_IDX_W-1:0] idx,
                           input logic [wbps_pkg::PDATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= wbps_pkg::PADDR_W'({idx, 3'b000});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    case (idx)
      wbps_pkg::REG_PATTERN_LENGTH: cfg_len = value[wbps_pkg::LEN_W-1:0];
      wbps_pkg::REG_PATTERN_WORD_0: cfg_word[0] = value;
      wbps_pkg::REG_PATTERN_WORD_1: cfg_word[1] = value;
      wbps_pkg::REG_PATTERN_WORD_2: cfg_word[2] = value;
      wbps_pkg::REG_PATTERN_WORD_3: cfg_word[3] = value;
      wbps_pkg::REG_CARE_MASK:      cfg_care = value[wbps_pkg::CARE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_config(input logic [wbps_pkg::LEN_W-1:0] len, input logic [63:0] w0,
                              input logic [63:0] w1, input logic [63:0] w2,
                              input logic [63:0] w3,
                              input logic [wbps_pkg::CARE_W-1:0] care);
    write_reg(wbps_pkg::REG_PATTERN_LENGTH, wbps_pkg::PDATA_W'(len));
    write_reg(wbps_pkg::REG_PATTERN_WORD_0, w0);
    write_reg(wbps_pkg::REG_PATTERN_WORD_1, w1);
    write_reg(wbps_pkg::REG_PATTERN_WORD_2, w2);
    write_reg(wbps_pkg::REG_PATTERN_WORD_3, w3);
    write_reg(wbps_pkg::REG_CARE_MASK, wbps_pkg::PDATA_W'(care));
    setting_cnt++;
  endtask

  // Build one buffer from planted pattern copies, near misses and loose bytes.
  task automatic send_random_buffer();
    logic [wbps_pkg::BYTE_W-1:0] bytes_q [$];
    int target;
    int pick;
    int unsigned len;
    int unsigned spot;
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 40);
    len = active_length();
    while (bytes_q.size() < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        spot = $urandom_range(0, len - 1);
        for (int unsigned i = 0; i < len; i++) begin
          if (pick == 0 && i == spot) begin
            bytes_q.push_back(pattern_byte(i) ^
                              wbps_pkg::BYTE_W'($urandom_range(1, 255)));
          end else if (cfg_care[i]) begin
            bytes_q.push_back(pattern_byte(i));
          end else begin
            bytes_q.push_back(wbps_pkg::BYTE_W'($urandom_range(0, 255)));
          end
        end
      end else if (pick < 6) begin
        bytes_q.push_back(wbps_pkg::BYTE_W'($urandom_range(0, 255)));
      end else begin
        bytes_q.push_back(pattern_byte($urandom_range(0, len - 1)));
      end
    end
    foreach (bytes_q[k]) begin
      send_byte(bytes_q[k], k == bytes_q.size() - 1);
    end
  endtask

  // Reset values: one-byte pattern of zero, every position cared for.
  task automatic test_reset_values();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    end_phase();
  endtask

  // Wildcard in the middle, a match at the last possible start, and no match
  // across a buffer boundary.
  task automatic test_wildcard_and_edges();
    write_config(6'd3, 64'h5A_00_FF, '0, '0, '0, 32'h5);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5A, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h33, 1'b1);
    send_byte(8'h5A, 1'b1);
    end_phase();
  endtask

  // Zero length acts as one; an all-wildcard pattern needs as many buffer bytes as its length.
  task automatic test_length_limits();
    write_config(6'd0, 64'h80, '0, '0, '0, '1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);
    end_phase();
    write_config(6'd2, '0, '0, '0, '0, '0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b1);
    end_phase();
  endtask

  // Every byte matches while the sink holds off, so the block must stall its input.
  task automatic test_backpressure();
    write_config(6'd1, '0, '0, '0, '0, '0);
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    for (int k = 0; k < 40; k++) begin
      send_byte(wbps_pkg::BYTE_W'($urandom_range(0, 255)), k == 39);
    end
    end_phase();
  endtask

  // Random settings, extremes first; the closing phases run without idling.
  task automatic test_random_settings();
    logic [wbps_pkg::LEN_W-1:0] len;
    logic [63:0] words [wbps_pkg::PATTERN_WORDS];
    logic [wbps_pkg::CARE_W-1:0] care;
    int goal;
    for (int p = 0; p < 12; p++) begin
      case (p)
        0: len = 6'd0;
        1: len = 6'd1;
        2: len = 6'd32;
        3: len = 6'd63;
        4: len = 6'd2;
        default: len = ($urandom_range(0, 3) == 0) ?
                       wbps_pkg::LEN_W'($urandom_range(0, 63)) :
                       wbps_pkg::LEN_W'($urandom_range(1, 12));
      endcase
      foreach (words[w]) begin
        words[w] = {$urandom, $urandom};
        if (p == 5) words[w] = '0;
        if (p == 6) words[w] = '1;
      end
      case (p)
        0, 7: care = '1;
        3: care = '0;
        default: care = ($urandom_range(0, 1) == 0) ?
                        wbps_pkg::CARE_W'($urandom) | wbps_pkg::CARE_W'($urandom) :
                        wbps_pkg::CARE_W'($urandom) & wbps_pkg::CARE_W'($urandom);
      endcase
      write_config(len, words[0], words[1], words[2], words[3], care);
      src_idle_en = (p < 9) && ($urandom_range(0, 3) != 0);
      sink_idle_en = (p < 9) && ($urandom_range(0, 3) != 0);
      goal = beats_sent + 60;
      while (beats_sent < goal) begin
        send_random_buffer();
      end
      end_phase();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_wildcard_and_edges();
    test_length_limits();
    test_backpressure();
    test_random_settings();

    $display("Sent %0d bytes under %0d register settings and checked %0d match offsets.",
             beats_sent, setting_cnt, offsets_checked);
    $display("Covered wildcards, length limits, buffer boundaries and a long output hold.");
    if (fail_cnt == 0 && offset_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
